[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the correlator checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define TEC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// implication whose consequent is checked in the next cycle
`define TEC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/tec_pkg.sv]
// ----------------------------------------------------------------------------
// tec_pkg
// types, codes and helpers shared by the transmit evidence correlator
// ----------------------------------------------------------------------------
package tec_pkg;

    // func codes on the input
    localparam logic [1:0] FUNC_SUBMIT   = 2'd0;
    localparam logic [1:0] FUNC_EVIDENCE = 2'd1;
    localparam logic [1:0] FUNC_SWEEP    = 2'd2;
    localparam logic [1:0] FUNC_UNUSED   = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_OVERFLOW  = 3'd1;
    localparam logic [2:0] ST_BAD_ID    = 3'd2;
    localparam logic [2:0] ST_CROSS_GEN = 3'd3;
    localparam logic [2:0] ST_DUPLICATE = 3'd4;
    localparam logic [2:0] ST_UNMATCHED = 3'd5;
    localparam logic [2:0] ST_EXPIRED   = 3'd6;

    // configuration register indexes
    localparam logic [2:0] CFG_GENERATION    = 3'd0;
    localparam logic [2:0] CFG_CORRELATE_EN  = 3'd1;
    localparam logic [2:0] CFG_FIRST_ID      = 3'd2;
    localparam logic [2:0] CFG_LAST_ID       = 3'd3;
    localparam logic [2:0] CFG_MAX_ENTRIES   = 3'd4;
    localparam logic [2:0] CFG_MAX_RESIDENCE = 3'd5;
    localparam logic [2:0] CFG_FAIL_ON_GAP   = 3'd6;

    // tally slots
    localparam int T_SUB     = 0;
    localparam int T_OBS     = 1;
    localparam int T_LATE    = 2;
    localparam int T_LOST    = 3;
    localparam int T_DUP     = 4;
    localparam int T_CROSS   = 5;
    localparam int T_UNM     = 6;
    localparam int NUM_TALLY = 7;

    localparam int QDEPTH = 2;

    typedef enum logic [1:0] {
        OP_SUBMIT,
        OP_EVIDENCE,
        OP_SWEEP,
        OP_NONE
    } op_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_CHECK,
        B_SCAN,
        B_FINISH,
        B_OUT
    } bstate_t;

    typedef struct packed {
        logic [31:0] generation;
        logic        correlate_enable;
        logic [31:0] first_id;
        logic [31:0] last_id;
        logic [6:0]  max_entries;
        logic [47:0] max_residence;
        logic        fail_on_gap;
    } cfg_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] endpoint;
        logic [31:0] id;
        logic [31:0] gen;
        logic [47:0] t;
    } item_t;

    // head of the item queue as seen by the back end
    typedef struct packed {
        logic  avail;
        item_t item;
    } queue_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    // deadline past 48 bits counts as already overdue
    function automatic logic overdue(input logic [47:0] t, input logic [47:0] now,
                                     input logic [47:0] res);
        logic [48:0] deadline;
        deadline = {1'b0, t} + {1'b0, res};
        return deadline[48] || (now > deadline[47:0]);
    endfunction

endpackage

[sv/tec_front.sv]
// ----------------------------------------------------------------------------
// tec_front
// accepts items, decodes the function and queues them for the back end
// ----------------------------------------------------------------------------
module tec_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [1:0]      func,
    input  logic [15:0]     endpoint,
    input  logic [31:0]     evidence_id,
    input  logic [31:0]     evidence_generation,
    input  logic [47:0]     time_now,
    output logic            busy,
    output tec_pkg::queue_t q,
    input  logic            pop
);
    import tec_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    item_t          q_mem [QDEPTH];
    logic [PW-1:0]  wp_reg, wp_next;
    logic [PW-1:0]  rp_reg, rp_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    item_t          in_item;
    logic           push;

    always_comb
    begin
        in_item.endpoint = endpoint;
        in_item.id       = evidence_id;
        in_item.gen      = evidence_generation;
        in_item.t        = time_now;
        case (func)
            FUNC_SUBMIT:   in_item.op = OP_SUBMIT;
            FUNC_EVIDENCE: in_item.op = OP_EVIDENCE;
            FUNC_SWEEP:    in_item.op = OP_SWEEP;
            default:       in_item.op = OP_NONE;
        endcase
    end

    assign busy    = (cnt_reg == CW'(QDEPTH));
    assign push    = start && !busy;
    assign q.avail = (cnt_reg != '0);
    assign q.item  = q_mem[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wp_next = (wp_reg == PW'(QDEPTH - 1)) ? '0 : wp_reg + PW'(1);
        end
        if (pop)
        begin
            rp_next = (rp_reg == PW'(QDEPTH - 1)) ? '0 : rp_reg + PW'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wp_reg] <= in_item;
        end
    end

endmodule

[sv/tec_back.sv]
// ----------------------------------------------------------------------------
// tec_back
// carries out queued items: pending table, recent window, tallies
// ----------------------------------------------------------------------------
module tec_back #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  tec_pkg::cfg_t   cfg,
    input  tec_pkg::queue_t q,
    output logic            pop,
    output logic            done,
    output logic [2:0]      status,
    output logic            late,
    output logic            coverage_complete,
    output logic [31:0]     submitted_count,
    output logic [31:0]     observed_count,
    output logic [31:0]     late_count,
    output logic [31:0]     lost_count,
    output logic [31:0]     duplicate_count,
    output logic [31:0]     cross_generation_count,
    output logic [31:0]     unmatched_count,
    output logic [6:0]      pending_count
);
    import tec_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int IW = AW + 1;
    localparam int CW = (IW > 7) ? IW : 7;
    localparam logic [6:0] DEPTH_CLIP = (TABLE_DEPTH > 127) ? 7'd127 : 7'(TABLE_DEPTH);

    bstate_t state_reg, state_next;
    item_t   cur_reg, cur_next;

    logic [2:0]  status_reg, status_next;
    logic        late_reg, late_next;
    logic        cov_reg, cov_next;
    logic [2:0]  sticky_reg, sticky_next;
    logic [31:0] tally_reg [NUM_TALLY];
    logic [31:0] tally_next [NUM_TALLY];
    logic [6:0]  pend_reg, pend_next;
    logic [6:0]  fill_reg, fill_next;
    logic [AW-1:0] oldest_reg, oldest_next;
    logic [31:0] lsid_reg, lsid_next;
    logic        lsv_reg, lsv_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;

    // scan pipeline
    logic [IW-1:0] idx_reg, idx_next;
    logic [AW-1:0] rptr_reg, rptr_next;
    logic          dv_reg, dv_next;
    logic [AW-1:0] didx_reg, didx_next;
    logic          drv_reg, drv_next;
    logic          phit_reg, phit_next;
    logic [AW-1:0] hidx_reg, hidx_next;
    logic [15:0]   hep_reg, hep_next;
    logic [47:0]   htime_reg, htime_next;
    logic          rhit_reg, rhit_next;
    logic          ffound_reg, ffound_next;
    logic [AW-1:0] fidx_reg, fidx_next;
    logic          swept_reg, swept_next;

    // memories
    logic [95:0]   pmem [TABLE_DEPTH];
    logic [95:0]   pq_reg;
    logic [31:0]   rmem [TABLE_DEPTH];
    logic [31:0]   rq_reg;
    logic          pwe, rwe;
    logic [AW-1:0] pwa, rwa;

    logic [6:0]  lim;
    logic        sub_full, sub_bad, chk_scan, issue, scan_end;
    logic [31:0] pid;
    logic [15:0] pep;
    logic [47:0] ptime;
    logic        pv, sweep_hit, sweep_stop;
    logic [IW-1:0] drop;

    function automatic logic [AW-1:0] wrap(input logic [IW-1:0] s);
        logic [IW-1:0] r;
        r = (s >= IW'(TABLE_DEPTH)) ? s - IW'(TABLE_DEPTH) : s;
        return r[AW-1:0];
    endfunction

    assign lim = (cfg.max_entries == 7'd0) ? 7'd1 :
                 (cfg.max_entries > DEPTH_CLIP) ? DEPTH_CLIP : cfg.max_entries;

    assign sub_full = (tally_reg[T_SUB] == 32'hFFFF_FFFF);
    assign sub_bad  = (cur_reg.id < cfg.first_id) || (cur_reg.id > cfg.last_id) ||
                      (lsv_reg && (cur_reg.id <= lsid_reg)) || (pend_reg >= lim);
    assign chk_scan = (sticky_reg == 3'd0) && cfg.correlate_enable &&
                      (((cur_reg.op == OP_SUBMIT) && !sub_full && !sub_bad) ||
                       ((cur_reg.op == OP_EVIDENCE) && (cur_reg.gen == cfg.generation)) ||
                       (cur_reg.op == OP_SWEEP));

    assign issue    = (state_reg == B_SCAN) && (idx_reg < IW'(TABLE_DEPTH));
    assign scan_end = (idx_reg == IW'(TABLE_DEPTH)) && !dv_reg;

    assign pid   = pq_reg[95:64];
    assign pep   = pq_reg[63:48];
    assign ptime = pq_reg[47:0];
    assign pv    = valid_reg[didx_reg];

    assign sweep_hit  = (state_reg == B_SCAN) && dv_reg && (cur_reg.op == OP_SWEEP) &&
                        pv && overdue(ptime, cur_reg.t, cfg.max_residence);
    assign sweep_stop = sweep_hit && cfg.fail_on_gap;

    // oldest entries dropped before an append
    assign drop = IW'(fill_reg) - IW'(lim) + IW'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:   if (q.avail) state_next = B_CHECK;
            B_CHECK:  state_next = chk_scan ? B_SCAN : B_OUT;
            B_SCAN:
            begin
                if (sweep_stop)
                begin
                    state_next = B_OUT;
                end
                else if (scan_end)
                begin
                    state_next = B_FINISH;
                end
            end
            B_FINISH: state_next = B_OUT;
            B_OUT:    state_next = B_IDLE;
            default:  state_next = B_IDLE;
        endcase
    end

    assign pop  = (state_reg == B_IDLE) && q.avail;
    assign done = (state_reg == B_OUT);

    // datapath
    always_comb
    begin
        cur_next    = cur_reg;
        status_next = status_reg;
        late_next   = late_reg;
        cov_next    = cov_reg;
        sticky_next = sticky_reg;
        for (int k = 0; k < NUM_TALLY; k++)
        begin
            tally_next[k] = tally_reg[k];
        end
        pend_next   = pend_reg;
        fill_next   = fill_reg;
        oldest_next = oldest_reg;
        lsid_next   = lsid_reg;
        lsv_next    = lsv_reg;
        valid_next  = valid_reg;
        idx_next    = idx_reg;
        rptr_next   = rptr_reg;
        dv_next     = 1'b0;
        didx_next   = didx_reg;
        drv_next    = drv_reg;
        phit_next   = phit_reg;
        hidx_next   = hidx_reg;
        hep_next    = hep_reg;
        htime_next  = htime_reg;
        rhit_next   = rhit_reg;
        ffound_next = ffound_reg;
        fidx_next   = fidx_reg;
        swept_next  = swept_reg;
        pwe = 1'b0;
        pwa = fidx_reg;
        rwe = 1'b0;
        rwa = wrap(IW'(oldest_reg) + IW'(fill_reg));

        case (state_reg)
            B_IDLE:
            begin
                if (q.avail)
                begin
                    cur_next = q.item;
                end
            end
            B_CHECK:
            begin
                status_next = ST_OK;
                late_next   = 1'b0;
                idx_next    = '0;
                rptr_next   = oldest_reg;
                phit_next   = 1'b0;
                rhit_next   = 1'b0;
                ffound_next = 1'b0;
                swept_next  = 1'b0;
                if (sticky_reg != 3'd0)
                begin
                    status_next = sticky_reg;
                end
                else
                begin
                    case (cur_reg.op)
                        OP_SUBMIT:
                        begin
                            if (sub_full)
                            begin
                                sticky_next = ST_OVERFLOW;
                                status_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                tally_next[T_SUB] = tally_reg[T_SUB] + 32'd1;
                                if (cfg.correlate_enable && sub_bad)
                                begin
                                    status_next = ST_BAD_ID;
                                    if (cfg.fail_on_gap) sticky_next = ST_BAD_ID;
                                end
                            end
                        end
                        OP_EVIDENCE:
                        begin
                            if (cfg.correlate_enable && (cur_reg.gen != cfg.generation))
                            begin
                                tally_next[T_CROSS] = sat_inc(tally_reg[T_CROSS]);
                                status_next = ST_CROSS_GEN;
                                if (cfg.fail_on_gap) sticky_next = ST_CROSS_GEN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            B_SCAN:
            begin
                if (issue)
                begin
                    idx_next  = idx_reg + IW'(1);
                    rptr_next = wrap(IW'(rptr_reg) + IW'(1));
                    dv_next   = 1'b1;
                    didx_next = idx_reg[AW-1:0];
                    drv_next  = CW'(idx_reg) < CW'(fill_reg);
                end
                if (dv_reg)
                begin
                    if (cur_reg.op == OP_SWEEP)
                    begin
                        if (sweep_hit)
                        begin
                            tally_next[T_LOST] = sat_inc(tally_reg[T_LOST]);
                            valid_next[didx_reg] = 1'b0;
                            pend_next  = pend_reg - 7'd1;
                            swept_next = 1'b1;
                            status_next = ST_EXPIRED;
                            if (cfg.fail_on_gap) sticky_next = ST_EXPIRED;
                        end
                    end
                    else
                    begin
                        if (pv && (pid == cur_reg.id) && !phit_reg)
                        begin
                            phit_next  = 1'b1;
                            hidx_next  = didx_reg;
                            hep_next   = pep;
                            htime_next = ptime;
                        end
                        if (drv_reg && (rq_reg == cur_reg.id))
                        begin
                            rhit_next = 1'b1;
                        end
                        if (!pv && !ffound_reg)
                        begin
                            ffound_next = 1'b1;
                            fidx_next   = didx_reg;
                        end
                    end
                end
            end
            B_FINISH:
            begin
                case (cur_reg.op)
                    OP_SUBMIT:
                    begin
                        if (phit_reg || rhit_reg)
                        begin
                            status_next = ST_BAD_ID;
                            if (cfg.fail_on_gap) sticky_next = ST_BAD_ID;
                        end
                        else
                        begin
                            pwe = 1'b1;
                            valid_next[fidx_reg] = 1'b1;
                            pend_next = pend_reg + 7'd1;
                            lsid_next = cur_reg.id;
                            lsv_next  = 1'b1;
                        end
                    end
                    OP_EVIDENCE:
                    begin
                        if (rhit_reg)
                        begin
                            tally_next[T_DUP] = sat_inc(tally_reg[T_DUP]);
                            status_next = ST_DUPLICATE;
                            if (cfg.fail_on_gap) sticky_next = ST_DUPLICATE;
                        end
                        else if (!phit_reg || (hep_reg != cur_reg.endpoint))
                        begin
                            tally_next[T_UNM] = sat_inc(tally_reg[T_UNM]);
                            status_next = ST_UNMATCHED;
                            if (cfg.fail_on_gap) sticky_next = ST_UNMATCHED;
                        end
                        else
                        begin
                            if (overdue(htime_reg, cur_reg.t, cfg.max_residence))
                            begin
                                late_next = 1'b1;
                                tally_next[T_LATE] = sat_inc(tally_reg[T_LATE]);
                            end
                            rwe = 1'b1;
                            if (fill_reg >= lim)
                            begin
                                oldest_next = wrap(IW'(oldest_reg) + drop);
                                fill_next   = lim;
                            end
                            else
                            begin
                                fill_next = fill_reg + 7'd1;
                            end
                            valid_next[hidx_reg] = 1'b0;
                            pend_next = pend_reg - 7'd1;
                            tally_next[T_OBS] = sat_inc(tally_reg[T_OBS]);
                        end
                    end
                    OP_SWEEP:
                    begin
                        cov_next = (tally_reg[T_SUB] != 32'd0) &&
                                   (tally_reg[T_OBS] == tally_reg[T_SUB]) &&
                                   (tally_reg[T_LATE] == 32'd0) &&
                                   (tally_reg[T_LOST] == 32'd0) &&
                                   (tally_reg[T_DUP] == 32'd0) &&
                                   (tally_reg[T_CROSS] == 32'd0) &&
                                   (tally_reg[T_UNM] == 32'd0);
                        status_next = swept_reg ? ST_EXPIRED : ST_OK;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            status_reg <= ST_OK;
            late_reg   <= 1'b0;
            cov_reg    <= 1'b0;
            sticky_reg <= 3'd0;
            for (int k = 0; k < NUM_TALLY; k++)
            begin
                tally_reg[k] <= 32'd0;
            end
            pend_reg   <= 7'd0;
            fill_reg   <= 7'd0;
            oldest_reg <= '0;
            lsid_reg   <= 32'd0;
            lsv_reg    <= 1'b0;
            valid_reg  <= '0;
            idx_reg    <= '0;
            rptr_reg   <= '0;
            dv_reg     <= 1'b0;
            drv_reg    <= 1'b0;
            phit_reg   <= 1'b0;
            rhit_reg   <= 1'b0;
            ffound_reg <= 1'b0;
            swept_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
            late_reg   <= late_next;
            cov_reg    <= cov_next;
            sticky_reg <= sticky_next;
            for (int k = 0; k < NUM_TALLY; k++)
            begin
                tally_reg[k] <= tally_next[k];
            end
            pend_reg   <= pend_next;
            fill_reg   <= fill_next;
            oldest_reg <= oldest_next;
            lsid_reg   <= lsid_next;
            lsv_reg    <= lsv_next;
            valid_reg  <= valid_next;
            idx_reg    <= idx_next;
            rptr_reg   <= rptr_next;
            dv_reg     <= dv_next;
            drv_reg    <= drv_next;
            phit_reg   <= phit_next;
            rhit_reg   <= rhit_next;
            ffound_reg <= ffound_next;
            swept_reg  <= swept_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        didx_reg  <= didx_next;
        hidx_reg  <= hidx_next;
        hep_reg   <= hep_next;
        htime_reg <= htime_next;
        fidx_reg  <= fidx_next;
    end

    // pending table: id, endpoint, submit time
    always_ff @(posedge clk)
    begin
        if (pwe)
        begin
            pmem[pwa] <= {cur_reg.id, cur_reg.endpoint, cur_reg.t};
        end
        pq_reg <= pmem[idx_reg[AW-1:0]];
    end

    // recent-observed ring
    always_ff @(posedge clk)
    begin
        if (rwe)
        begin
            rmem[rwa] <= cur_reg.id;
        end
        rq_reg <= rmem[rptr_reg];
    end

    assign status                 = status_reg;
    assign late                   = late_reg;
    assign coverage_complete      = cov_reg;
    assign submitted_count        = tally_reg[T_SUB];
    assign observed_count         = tally_reg[T_OBS];
    assign late_count             = tally_reg[T_LATE];
    assign lost_count             = tally_reg[T_LOST];
    assign duplicate_count        = tally_reg[T_DUP];
    assign cross_generation_count = tally_reg[T_CROSS];
    assign unmatched_count        = tally_reg[T_UNM];
    assign pending_count          = pend_reg;

endmodule

[sv/transmit_evidence_correlator_top.sv]
// ----------------------------------------------------------------------------
// transmit_evidence_correlator_top
// matches submitted datagram ids against transmit confirmations
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  ---------------------------
//  item      in         start, busy               func, endpoint, evidence_id,
//                                                 evidence_generation, time_now
//  result    out        done (one-cycle strobe)   status, late, coverage and
//                                                 tallies, pending_count
//  config    in         cfg_valid, cfg_ready      cfg_index, cfg_data
//
//  an item ends early (sticky failure, overflow, disabled correlation, bad
//  range, id not rising, table full, wrong generation, unused function) or
//  else walks the pending table and recent ring, one entry per
//  cycle through the single read port of each memory
//  a two-entry queue takes items while the back end works; busy is queue full
//  rst_n clears control state, tallies and valid bits at once; the table
//  memories hold no reset and are only read where written
//  the receiver cannot stall: each result transaction shows for one cycle
// ----------------------------------------------------------------------------
module transmit_evidence_correlator_top #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // item transaction
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [15:0] endpoint,
    input  logic [31:0] evidence_id,
    input  logic [31:0] evidence_generation,
    input  logic [47:0] time_now,
    // result transaction
    output logic        done,
    output logic [2:0]  status,
    output logic        late,
    output logic        coverage_complete,
    output logic [31:0] submitted_count,
    output logic [31:0] observed_count,
    output logic [31:0] late_count,
    output logic [31:0] lost_count,
    output logic [31:0] duplicate_count,
    output logic [31:0] cross_generation_count,
    output logic [31:0] unmatched_count,
    output logic [6:0]  pending_count,
    // configuration write transaction
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data
);
    import tec_pkg::*;

    cfg_t   cfg_reg;
    queue_t q;
    logic   pop;

    // config writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.generation       <= 32'd1;
            cfg_reg.correlate_enable <= 1'b0;
            cfg_reg.first_id         <= 32'd0;
            cfg_reg.last_id          <= 32'hFFFF_FFFF;
            cfg_reg.max_entries      <= 7'd64;
            cfg_reg.max_residence    <= 48'd0;
            cfg_reg.fail_on_gap      <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_GENERATION:    cfg_reg.generation       <= cfg_data[31:0];
                CFG_CORRELATE_EN:  cfg_reg.correlate_enable <= cfg_data[0];
                CFG_FIRST_ID:      cfg_reg.first_id         <= cfg_data[31:0];
                CFG_LAST_ID:       cfg_reg.last_id          <= cfg_data[31:0];
                CFG_MAX_ENTRIES:   cfg_reg.max_entries      <= cfg_data[6:0];
                CFG_MAX_RESIDENCE: cfg_reg.max_residence    <= cfg_data;
                CFG_FAIL_ON_GAP:   cfg_reg.fail_on_gap      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // front end: capture and decode
    tec_front u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .func                (func),
        .endpoint            (endpoint),
        .evidence_id         (evidence_id),
        .evidence_generation (evidence_generation),
        .time_now            (time_now),
        .busy                (busy),
        .q                   (q),
        .pop                 (pop)
    );

    // back end: table walks and tallies
    tec_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .cfg                    (cfg_reg),
        .q                      (q),
        .pop                    (pop),
        .done                   (done),
        .status                 (status),
        .late                   (late),
        .coverage_complete      (coverage_complete),
        .submitted_count        (submitted_count),
        .observed_count         (observed_count),
        .late_count             (late_count),
        .lost_count             (lost_count),
        .duplicate_count        (duplicate_count),
        .cross_generation_count (cross_generation_count),
        .unmatched_count        (unmatched_count),
        .pending_count          (pending_count)
    );

endmodule

[sv/tec_checker.sv]
// ----------------------------------------------------------------------------
// tec_checker
// port-level checks on the correlator, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tec_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        done,
    input logic [2:0]  status,
    input logic        late,
    input logic [31:0] submitted_count
);
    import tec_pkg::*;

    // result strobe lasts a single cycle
    `TEC_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done, "done held two cycles")

    // a late match is still an accepted match
    `TEC_ASSERT(a_late_ok, clk, rst_n, !late || (status == ST_OK), "late with error status")

    // submission count never goes back
    `TEC_ASSERT(a_sub_mono, clk, rst_n, submitted_count >= $past(submitted_count), "count fell")

endmodule

bind transmit_evidence_correlator_top tec_checker u_tec_checker (.*);

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the transmit evidence correlator: a directed table
// of submit, evidence, sweep and unused transactions, then random phases of
// well-formed submit/confirm traffic mixed with noise, each result checked
// field by field against a predictor
// ----------------------------------------------------------------------------
module tb;
    import tec_pkg::*;

    localparam int DEPTH = 64;

    // one row of the directed table; typed rows carry their status and late
    typedef struct {
        logic [1:0]  fn;
        logic [15:0] ep;
        logic [31:0] id;
        logic [31:0] gen;
        logic [47:0] t;
        bit          typed;
        logic [2:0]  st;
        logic        lt;
    } row_t;

    // one expected result transaction
    typedef struct {
        logic [2:0]  st;
        logic        lt;
        logic        cov;
        logic [31:0] tally [NUM_TALLY];
        logic [6:0]  pend;
    } res_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  func;
    logic [15:0] endpoint;
    logic [31:0] evidence_id;
    logic [31:0] evidence_generation;
    logic [47:0] time_now;
    logic        done;
    logic [2:0]  status;
    logic        late;
    logic        coverage_complete;
    logic [31:0] submitted_count;
    logic [31:0] observed_count;
    logic [31:0] late_count;
    logic [31:0] lost_count;
    logic [31:0] duplicate_count;
    logic [31:0] cross_generation_count;
    logic [31:0] unmatched_count;
    logic [6:0]  pending_count;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [47:0] cfg_data;

    transmit_evidence_correlator_top #(.TABLE_DEPTH(DEPTH)) dut (.*);

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // predictor copy of the configuration
    logic [31:0] m_gen;
    logic        m_enable;
    logic [31:0] m_first;
    logic [31:0] m_last;
    logic [6:0]  m_max_entries;
    logic [47:0] m_residence;
    logic        m_fail_on_gap;

    // predictor copy of the state
    logic        pv_valid [DEPTH];
    logic [31:0] pv_id    [DEPTH];
    logic [15:0] pv_ep    [DEPTH];
    logic [47:0] pv_time  [DEPTH];
    logic [31:0] seen_ids [DEPTH];
    int          seen_fill;
    logic [31:0] last_id_taken;
    logic        last_id_known;
    logic [31:0] tally [NUM_TALLY];
    logic        cov_flag;
    logic [2:0]  sticky;
    int          pend_n;

    res_t  awaiting [$];
    int    fails;
    row_t  rows_off [$];
    row_t  rows_on  [$];
    bit    calm;            // no sender idling while set
    logic [31:0] next_id;   // rising id for well-formed submits
    logic [47:0] clock_now; // rising time for well-formed traffic

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic int entry_limit();
        if (m_max_entries == 7'd0)
            return 1;
        if (int'(m_max_entries) > DEPTH)
            return DEPTH;
        return int'(m_max_entries);
    endfunction

    function automatic void tally_up(int k);
        if (tally[k] != 32'hFFFF_FFFF)
            tally[k] = tally[k] + 32'd1;
    endfunction

    function automatic bit past_deadline(logic [47:0] t0, logic [47:0] now);
        logic [48:0] dl;
        dl = {1'b0, t0} + {1'b0, m_residence};
        return dl[48] || (now > dl[47:0]);
    endfunction

    function automatic bit recently_seen(logic [31:0] id);
        for (int i = 0; i < seen_fill; i++)
            if (seen_ids[i] == id)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic int pending_slot(logic [31:0] id);
        for (int i = 0; i < DEPTH; i++)
            if (pv_valid[i] && pv_id[i] == id)
                return i;
        return -1;
    endfunction

    // gap code; under fail policy it sticks
    function automatic logic [2:0] raise_gap(logic [2:0] code);
        if (m_fail_on_gap)
            sticky = code;
        return code;
    endfunction

    function automatic logic [2:0] submit_item(logic [15:0] ep, logic [31:0] id,
                                               logic [47:0] t);
        if (tally[T_SUB] == 32'hFFFF_FFFF)
        begin
            sticky = ST_OVERFLOW;
            return ST_OVERFLOW;
        end
        tally[T_SUB] = tally[T_SUB] + 32'd1;
        if (!m_enable)
            return ST_OK;
        if (id < m_first || id > m_last || (last_id_known && id <= last_id_taken) ||
            pend_n >= entry_limit() || pending_slot(id) >= 0 || recently_seen(id))
            return raise_gap(ST_BAD_ID);
        for (int i = 0; i < DEPTH; i++)
        begin
            if (!pv_valid[i])
            begin
                pv_valid[i] = 1'b1;
                pv_id[i]    = id;
                pv_ep[i]    = ep;
                pv_time[i]  = t;
                pend_n++;
                break;
            end
        end
        last_id_taken = id;
        last_id_known = 1'b1;
        return ST_OK;
    endfunction

    function automatic logic [2:0] confirm_item(logic [15:0] ep, logic [31:0] id,
                                                logic [31:0] gen, logic [47:0] now,
                                                output logic lt);
        int slot;
        lt = 1'b0;
        if (!m_enable)
            return ST_OK;
        if (gen != m_gen)
        begin
            tally_up(T_CROSS);
            return raise_gap(ST_CROSS_GEN);
        end
        if (recently_seen(id))
        begin
            tally_up(T_DUP);
            return raise_gap(ST_DUPLICATE);
        end
        slot = pending_slot(id);
        if (slot < 0 || pv_ep[slot] != ep)
        begin
            tally_up(T_UNM);
            return raise_gap(ST_UNMATCHED);
        end
        if (past_deadline(pv_time[slot], now))
        begin
            tally_up(T_LATE);
            lt = 1'b1;
        end
        // drop the oldest ids until the new one fits the window
        while (seen_fill >= entry_limit() && seen_fill > 0)
        begin
            for (int i = 0; i < seen_fill - 1; i++)
                seen_ids[i] = seen_ids[i + 1];
            seen_fill--;
        end
        seen_ids[seen_fill] = id;
        seen_fill++;
        pv_valid[slot] = 1'b0;
        pend_n--;
        tally_up(T_OBS);
        return ST_OK;
    endfunction

    function automatic logic [2:0] sweep_item(logic [47:0] now);
        logic [2:0] st;
        st = ST_OK;
        if (!m_enable)
            return ST_OK;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (pv_valid[i] && past_deadline(pv_time[i], now))
            begin
                tally_up(T_LOST);
                pv_valid[i] = 1'b0;
                pend_n--;
                st = raise_gap(ST_EXPIRED);
                if (sticky != ST_OK)
                    return st;
            end
        end
        cov_flag = tally[T_SUB] != 0 && tally[T_OBS] == tally[T_SUB] &&
                   tally[T_LATE] == 0 && tally[T_LOST] == 0 && tally[T_DUP] == 0 &&
                   tally[T_CROSS] == 0 && tally[T_UNM] == 0;
        return st;
    endfunction

    // advance the predictor by one item and return the result it causes
    function automatic res_t correlate(logic [1:0] fn, logic [15:0] ep,
                                       logic [31:0] id, logic [31:0] gen,
                                       logic [47:0] t);
        res_t r;
        r.lt = 1'b0;
        r.st = ST_OK;
        if (sticky != ST_OK)
            r.st = sticky;
        else if (fn == FUNC_SUBMIT)
            r.st = submit_item(ep, id, t);
        else if (fn == FUNC_EVIDENCE)
            r.st = confirm_item(ep, id, gen, t, r.lt);
        else if (fn == FUNC_SWEEP)
            r.st = sweep_item(t);
        r.cov = cov_flag;
        for (int k = 0; k < NUM_TALLY; k++)
            r.tally[k] = tally[k];
        r.pend = pend_n[6:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result checker: every done strobe is a result transaction
    // ------------------------------------------------------------------
    function automatic void compare(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t mismatch %s expected %h actual %h", $realtime, name, want, got);
            fails++;
        end
    endfunction

    always @(posedge clk)
    begin
        res_t e;
        if (rst_n && done)
        begin
            if (awaiting.size() == 0)
            begin
                $display("%0t unexpected result transaction status %h", $realtime, status);
                fails++;
            end
            else
            begin
                e = awaiting.pop_front();
                compare("status", 32'(e.st), 32'(status));
                compare("late", 32'(e.lt), 32'(late));
                compare("coverage_complete", 32'(e.cov), 32'(coverage_complete));
                compare("submitted_count", e.tally[T_SUB], submitted_count);
                compare("observed_count", e.tally[T_OBS], observed_count);
                compare("late_count", e.tally[T_LATE], late_count);
                compare("lost_count", e.tally[T_LOST], lost_count);
                compare("duplicate_count", e.tally[T_DUP], duplicate_count);
                compare("cross_generation_count", e.tally[T_CROSS], cross_generation_count);
                compare("unmatched_count", e.tally[T_UNM], unmatched_count);
                compare("pending_count", 32'(e.pend), 32'(pending_count));
            end
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // wait out every pending result, then the longest item walk
    task automatic settle();
        while (awaiting.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 8) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [47:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_GENERATION:    m_gen = value[31:0];
            CFG_CORRELATE_EN:  m_enable = value[0];
            CFG_FIRST_ID:      m_first = value[31:0];
            CFG_LAST_ID:       m_last = value[31:0];
            CFG_MAX_ENTRIES:   m_max_entries = value[6:0];
            CFG_MAX_RESIDENCE: m_residence = value[47:0];
            CFG_FAIL_ON_GAP:   m_fail_on_gap = value[0];
            default: ;
        endcase
    endtask

    task automatic set_all(logic [31:0] gen, logic en, logic [31:0] lo, logic [31:0] hi,
                           logic [6:0] lim, logic [47:0] res, logic fog);
        settle();
        write_reg(CFG_GENERATION, {16'd0, gen});
        write_reg(CFG_CORRELATE_EN, {47'd0, en});
        write_reg(CFG_FIRST_ID, {16'd0, lo});
        write_reg(CFG_LAST_ID, {16'd0, hi});
        write_reg(CFG_MAX_ENTRIES, {41'd0, lim});
        write_reg(CFG_MAX_RESIDENCE, res);
        write_reg(CFG_FAIL_ON_GAP, {47'd0, fog});
    endtask

    // one item transaction; start stays high into the next item unless idling
    task automatic send(logic [1:0] fn, logic [15:0] ep, logic [31:0] id,
                        logic [31:0] gen, logic [47:0] t, bit typed,
                        logic [2:0] st, logic lt);
        res_t r;
        start               <= 1'b1;
        func                <= fn;
        endpoint            <= ep;
        evidence_id         <= id;
        evidence_generation <= gen;
        time_now            <= t;
        do
            @(posedge clk);
        while (busy);
        r = correlate(fn, ep, id, gen, t);
        if (typed)
        begin
            r.st = st;
            r.lt = lt;
        end
        awaiting = {awaiting, r};
        if (!calm && $urandom_range(0, 99) < 36)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic walk(ref row_t tbl [$]);
        foreach (tbl[i])
            send(tbl[i].fn, tbl[i].ep, tbl[i].id, tbl[i].gen, tbl[i].t,
                 tbl[i].typed, tbl[i].st, tbl[i].lt);
        start <= 1'b0;
    endtask

    function automatic void add_row(ref row_t tbl [$], input row_t r);
        tbl = {tbl, r};
    endfunction

    function automatic logic [47:0] any48();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[47:0];
    endfunction

    // mostly well-formed submit and confirm traffic, some noise
    task automatic random_items(int count);
        int pick;
        int slot;
        logic [1:0] fn;
        logic [15:0] ep;
        logic [31:0] id;
        logic [31:0] gen;
        logic [47:0] t;
        for (int n = 0; n < count; n++)
        begin
            clock_now = clock_now + 48'($urandom_range(0, 8));
            pick = $urandom_range(0, 99);
            fn  = FUNC_EVIDENCE;
            ep  = 16'($urandom());
            id  = $urandom();
            gen = m_gen;
            t   = clock_now;
            if (pick < 38)
            begin
                fn = FUNC_SUBMIT;
                next_id = next_id + 32'($urandom_range(1, 3));
                id = next_id;
            end
            else if (pick < 72)
            begin
                // confirm a pending entry, usually with its own endpoint
                slot = -1;
                for (int k = 0, s = $urandom_range(0, DEPTH - 1); k < DEPTH; k++)
                    if (slot < 0 && pv_valid[(s + k) % DEPTH])
                        slot = (s + k) % DEPTH;
                if (slot >= 0)
                begin
                    id = pv_id[slot];
                    ep = ($urandom_range(0, 9) == 0) ? ep : pv_ep[slot];
                end
            end
            else if (pick < 78)
            begin
                if (seen_fill > 0)
                    id = seen_ids[$urandom_range(0, seen_fill - 1)];
            end
            else if (pick < 82)
                gen = $urandom();
            else if (pick < 89)
                fn = FUNC_SWEEP;
            else if (pick < 94)
            begin
                fn = FUNC_SUBMIT;
                t  = any48();
            end
            else if (pick < 97)
            begin
                fn = FUNC_UNUSED;
                t  = any48();
            end
            else
                t = any48();
            send(fn, ep, id, gen, t, 1'b0, ST_OK, 1'b0);
        end
        start <= 1'b0;
    endtask

    function automatic row_t mk(logic [1:0] fn, logic [15:0] ep, logic [31:0] id,
                                logic [31:0] gen, logic [47:0] t,
                                logic [2:0] st, logic lt);
        row_t r;
        r.fn = fn; r.ep = ep; r.id = id; r.gen = gen; r.t = t;
        r.typed = 1'b1; r.st = st; r.lt = lt;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [6:0]  lims [7];
        logic [47:0] ress [4];
        logic [31:0] lo;
        logic [31:0] hi;

        lims = '{7'd0, 7'd1, 7'd5, 7'd64, 7'd127, 7'd12, 7'd3};
        ress = '{48'd0, 48'd25, 48'd300, 48'hFFFF_FFFF_FFFF};

        start               <= 1'b0;
        func                <= FUNC_SUBMIT;
        endpoint            <= '0;
        evidence_id         <= '0;
        evidence_generation <= '0;
        time_now            <= '0;
        cfg_valid           <= 1'b0;
        cfg_index           <= CFG_GENERATION;
        cfg_data            <= '0;
        rst_n = 1'b0;

        // reset values of the predictor
        m_gen = 32'd1; m_enable = 1'b0; m_first = '0; m_last = 32'hFFFF_FFFF;
        m_max_entries = 7'd64; m_residence = '0; m_fail_on_gap = 1'b0;
        foreach (pv_valid[i])
            pv_valid[i] = 1'b0;
        seen_fill = 0; last_id_known = 1'b0; last_id_taken = '0;
        foreach (tally[k])
            tally[k] = '0;
        cov_flag = 1'b0; sticky = ST_OK; pend_n = 0; fails = 0; calm = 1'b0;
        clock_now = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // correlation off after reset: everything is ok, submits only count
        add_row(rows_off, mk(FUNC_SUBMIT, 16'h0001, 32'd5, 32'd1, 48'd0, ST_OK, 1'b0));
        add_row(rows_off, mk(FUNC_EVIDENCE, 16'h0001, 32'd5, 32'd1, 48'd1, ST_OK, 1'b0));
        add_row(rows_off, mk(FUNC_SWEEP, 16'h0000, 32'd0, 32'd0, 48'hFFFF_FFFF_FFFF,
                             ST_OK, 1'b0));
        add_row(rows_off, mk(FUNC_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             48'hFFFF_FFFF_FFFF, ST_OK, 1'b0));
        walk(rows_off);

        // range 100..200, two entries, ten ticks of residence
        set_all(32'd5, 1'b1, 32'd100, 32'd200, 7'd2, 48'd10, 1'b0);
        add_row(rows_on, mk(FUNC_SUBMIT, 16'd7, 32'd99, 32'd5, 48'd0, ST_BAD_ID, 1'b0));
        add_row(rows_on, mk(FUNC_SUBMIT, 16'd7, 32'd201, 32'd5, 48'd0, ST_BAD_ID, 1'b0));
        add_row(rows_on, mk(FUNC_SUBMIT, 16'd7, 32'd100, 32'd5, 48'd0, ST_OK, 1'b0));
        // not strictly rising
        add_row(rows_on, mk(FUNC_SUBMIT, 16'd7, 32'd100, 32'd5, 48'd1, ST_BAD_ID, 1'b0));
        add_row(rows_on, mk(FUNC_SUBMIT, 16'hFFFF, 32'd150, 32'd5, 48'd5, ST_OK, 1'b0));
        // table full
        add_row(rows_on, mk(FUNC_SUBMIT, 16'd7, 32'd160, 32'd5, 48'd5, ST_BAD_ID, 1'b0));
        add_row(rows_on, mk(FUNC_EVIDENCE, 16'd7, 32'd100, 32'd4, 48'd6,
                            ST_CROSS_GEN, 1'b0));
        // id matches but endpoint does not
        add_row(rows_on, mk(FUNC_EVIDENCE, 16'd8, 32'd100, 32'd5, 48'd6,
                            ST_UNMATCHED, 1'b0));
        // one tick past the deadline
        add_row(rows_on, mk(FUNC_EVIDENCE, 16'd7, 32'd100, 32'd5, 48'd11, ST_OK, 1'b1));
        add_row(rows_on, mk(FUNC_EVIDENCE, 16'd7, 32'd100, 32'd5, 48'd12,
                            ST_DUPLICATE, 1'b0));
        // deadline beyond 48 bits counts as overdue
        add_row(rows_on, mk(FUNC_SUBMIT, 16'd0, 32'd200, 32'd5, 48'hFFFF_FFFF_FFFF,
                            ST_OK, 1'b0));
        add_row(rows_on, mk(FUNC_SWEEP, 16'd0, 32'd0, 32'd0, 48'd12, ST_EXPIRED, 1'b0));
        add_row(rows_on, mk(FUNC_EVIDENCE, 16'hFFFF, 32'd150, 32'd5, 48'd15, ST_OK, 1'b0));
        add_row(rows_on, mk(FUNC_SWEEP, 16'd0, 32'd0, 32'd0, 48'd20, ST_OK, 1'b0));
        add_row(rows_on, mk(FUNC_UNUSED, 16'd0, 32'd0, 32'd0, 48'd0, ST_OK, 1'b0));
        add_row(rows_on, mk(FUNC_EVIDENCE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            48'hFFFF_FFFF_FFFF, ST_CROSS_GEN, 1'b0));
        walk(rows_on);

        // random phases over a spread of settings, report policy
        next_id = 32'd200;
        clock_now = 48'd100;
        for (int p = 0; p < 8; p++)
        begin
            calm = (p == 3);
            if (p == 6)
                next_id = 32'hFFFF_F000;
            lo = (p % 2 == 0) ? 32'd0 : next_id;
            hi = (p % 3 == 0) ? 32'hFFFF_FFFF : next_id + 32'd600;
            set_all((p == 2) ? 32'hFFFF_FFFF : ((p == 5) ? 32'd1 : $urandom()),
                    (p != 4), lo, hi, lims[p % 7], ress[p % 4], 1'b0);
            random_items(200);
        end

        // fail policy last, since a sticky failure stops all further work
        calm = 1'b0;
        set_all(m_gen, 1'b1, 32'd0, 32'hFFFF_FFFF, 7'd16, 48'd40, 1'b1);
        random_items(80);

        settle();
        if (fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // hard stop well past the slowest correct run
    initial
    begin
        #30ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
